// ===== hdl/abtn_pkg.sv =====
// Shared types and constants for the angular binning block.
`default_nettype none
package abtn_pkg;

    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_GRID_ROWS = 64;
    localparam int DEF_KEEP_N    = 8;

    localparam logic [15:0] HVS_RESET = 16'd16962;

    // Widest grid index and the divider geometry.
    localparam int IDX_W     = 10;
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 18;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BIN,
        S_FILL_RD,
        S_FILL_DATA,
        S_SCAN_RD,
        S_SCAN_EV,
        S_TAIL,
        S_RD_ISSUE,
        S_RD_DATA,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SINE,
        B_SUM,
        B_MUL,
        B_IDX,
        B_QWAIT,
        B_FIN
    } t_bin_state;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
    } t_bin_res;

endpackage
`default_nettype wire

// ===== hdl/angular_bin_top_n_reflectivity_core.sv =====
// Top level: angular binning of sonar points with the strongest returns kept per cell.
// A read passes through the states RD_ISSUE, RD_DATA and OUT before its result is
// registered; an insert needs up to four divisions on the shared divider, a fill read,
// a scan of each entry held and a tail write. One request at a time: the next is taken
// once its result is in the output register. Reset: synchronous, active low; the fill
// memory is then cleared, one cell a cycle, before the first request is taken.
`default_nettype none
module angular_bin_top_n_reflectivity_core #(
    parameter int GRID_COLS = abtn_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = abtn_pkg::DEF_GRID_ROWS,
    parameter int KEEP_N    = abtn_pkg::DEF_KEEP_N
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: half view sine, unsigned Q0.16.
    input  wire logic        i_cfg_wen,
    input  wire logic [15:0] i_cfg_wdata,
    // Request stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // pos_x[15:0], pos_y[31:16], point_range[47:32], reflectivity[63:48],
    // read_col[69:64], read_row[75:70], read_slot[78:76], zero pad[79]
    input  wire logic [79:0] i_s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]  i_s_axis_tuser,
    // Result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // binned[0], bin_col[6:1], bin_row[12:7], slot_valid[13],
    // slot_reflectivity[29:14], slot_range[45:30], zero pad[47:46]
    output logic [47:0]      o_m_axis_tdata
);

    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int CELL_W = $clog2(NCELLS);
    localparam int ST_D   = NCELLS * KEEP_N;
    localparam int ST_W   = $clog2(ST_D);
    localparam int FILL_W = $clog2(KEEP_N + 1);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NCELLS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(KEEP_N);

    // Request fields as they arrive.
    logic               in_op;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic [15:0]        in_rng;
    logic [15:0]        in_refl;
    logic [5:0]         in_col;
    logic [5:0]         in_row;
    logic [2:0]         in_slot;
    logic               in_accept;

    assign in_op     = i_s_axis_tuser[0];
    assign in_x      = i_s_axis_tdata[15:0];
    assign in_y      = i_s_axis_tdata[31:16];
    assign in_rng    = i_s_axis_tdata[47:32];
    assign in_refl   = i_s_axis_tdata[63:48];
    assign in_col    = i_s_axis_tdata[69:64];
    assign in_row    = i_s_axis_tdata[75:70];
    assign in_slot   = i_s_axis_tdata[78:76];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    abtn_pkg::t_state r_state, n_state;

    logic [15:0]       r_hvs;
    logic [CELL_W-1:0] r_clr;
    logic [CELL_W-1:0] r_cell;
    logic [ST_W-1:0]   r_base;
    logic [FILL_W-1:0] r_j;
    logic [FILL_W-1:0] r_fill;
    logic              r_placed;
    logic [31:0]       r_carry;
    logic [15:0]       r_refl;
    logic [15:0]       r_rng;
    logic              r_rd_oob;

    // Result being assembled, then the output register.
    logic        r_binned;
    logic [5:0]  r_bcol;
    logic [5:0]  r_brow;
    logic        r_sv;
    logic [15:0] r_srefl;
    logic [15:0] r_srng;
    logic        r_mv;
    logic [47:0] r_mdata;

    // Memory ports.
    logic              fl_we;
    logic [CELL_W-1:0] fl_waddr;
    logic [FILL_W-1:0] fl_wdata;
    logic [FILL_W-1:0] fl_rdata;
    logic              st_we;
    logic [ST_W-1:0]   st_waddr;
    logic [31:0]       st_wdata;
    logic [ST_W-1:0]   st_raddr;
    logic [31:0]       st_rdata;

    logic               bin_start;
    logic               bin_done;
    abtn_pkg::t_bin_res bin_res;

    logic [CELL_W-1:0] rd_cell;
    logic [CELL_W-1:0] ins_cell;
    logic              rd_oob;
    logic [31:0]       new_entry;
    logic              out_free;
    logic              scan_write;

    assign rd_cell  = CELL_W'(int'(in_col) * GRID_ROWS + int'(in_row));
    assign ins_cell = CELL_W'(int'(bin_res.col) * GRID_ROWS + int'(bin_res.row));
    assign rd_oob   = (int'(in_col) >= GRID_COLS) || (int'(in_row) >= GRID_ROWS) ||
                      (int'(in_slot) >= KEEP_N);
    assign new_entry = {r_refl, r_rng};
    assign out_free  = !r_mv || i_m_axis_tready;
    // A stored entry of equal strength keeps its place ahead of the newcomer.
    assign scan_write = r_placed || (st_rdata[31:16] < r_refl);
    assign st_raddr   = r_base + ST_W'(r_j);
    assign fl_wdata   = (r_state == abtn_pkg::S_CLEAR) ? '0 : r_fill + FILL_W'(1);
    assign fl_waddr   = (r_state == abtn_pkg::S_CLEAR) ? r_clr : r_cell;
    assign st_wdata   = r_placed ? r_carry : new_entry;
    assign st_waddr   = r_base + ST_W'((r_state == abtn_pkg::S_TAIL) ? r_fill : r_j);

    abtn_ram #(
        .WIDTH (FILL_W),
        .DEPTH (NCELLS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_raddr (r_cell),
        .o_rdata (fl_rdata)
    );

    abtn_ram #(
        .WIDTH (32),
        .DEPTH (ST_D)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    abtn_bin #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_bin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (bin_start),
        .i_pos_x       (in_x),
        .i_pos_y       (in_y),
        .i_point_range (in_rng),
        .i_hvs         (r_hvs),
        .o_done        (bin_done),
        .o_res         (bin_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abtn_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: the insert scan reads one slot, then writes the shifted entry back
    // to it, so a read never meets a pending write to the same slot.
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        bin_start       = 1'b0;
        fl_we           = 1'b0;
        st_we           = 1'b0;
        case (r_state)
            abtn_pkg::S_CLEAR: begin
                fl_we = 1'b1;
                if (r_clr == LAST_CELL) begin
                    n_state = abtn_pkg::S_IDLE;
                end
            end
            abtn_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (in_op == abtn_pkg::OP_READ) begin
                        n_state = abtn_pkg::S_RD_ISSUE;
                    end else begin
                        bin_start = 1'b1;
                        n_state   = abtn_pkg::S_BIN;
                    end
                end
            end
            abtn_pkg::S_BIN: begin
                if (bin_done) begin
                    n_state = bin_res.ok ? abtn_pkg::S_FILL_RD : abtn_pkg::S_OUT;
                end
            end
            abtn_pkg::S_FILL_RD: begin
                n_state = abtn_pkg::S_FILL_DATA;
            end
            abtn_pkg::S_FILL_DATA: begin
                n_state = (fl_rdata == '0) ? abtn_pkg::S_TAIL : abtn_pkg::S_SCAN_RD;
            end
            abtn_pkg::S_SCAN_RD: begin
                n_state = abtn_pkg::S_SCAN_EV;
            end
            abtn_pkg::S_SCAN_EV: begin
                st_we   = scan_write;
                n_state = (r_j + FILL_W'(1) < r_fill) ? abtn_pkg::S_SCAN_RD
                                                      : abtn_pkg::S_TAIL;
            end
            abtn_pkg::S_TAIL: begin
                st_we   = (r_fill < FILL_FULL);
                fl_we   = (r_fill < FILL_FULL);
                n_state = abtn_pkg::S_OUT;
            end
            abtn_pkg::S_RD_ISSUE: begin
                n_state = abtn_pkg::S_RD_DATA;
            end
            abtn_pkg::S_RD_DATA: begin
                n_state = abtn_pkg::S_OUT;
            end
            abtn_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = abtn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = abtn_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers: configuration, clearing pass and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvs <= abtn_pkg::HVS_RESET;
            r_clr <= '0;
            r_mv  <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_hvs <= i_cfg_wdata;
            end
            if (r_state == abtn_pkg::S_CLEAR) begin
                r_clr <= r_clr + CELL_W'(1);
            end
            if (r_state == abtn_pkg::S_OUT && out_free) begin
                r_mv <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == abtn_pkg::S_OUT && out_free) begin
            r_mdata <= {2'b00, r_srng, r_srefl, r_sv, r_brow, r_bcol, r_binned};
        end
        case (r_state)
            abtn_pkg::S_IDLE: begin
                if (in_accept) begin
                    r_binned <= 1'b0;
                    r_bcol   <= '0;
                    r_brow   <= '0;
                    r_sv     <= 1'b0;
                    r_srefl  <= '0;
                    r_srng   <= '0;
                    r_refl   <= in_refl;
                    r_rng    <= in_rng;
                    r_cell   <= rd_cell;
                    r_base   <= ST_W'(int'(rd_cell) * KEEP_N);
                    r_j      <= FILL_W'(in_slot);
                    r_rd_oob <= rd_oob;
                end
            end
            abtn_pkg::S_BIN: begin
                if (bin_done && bin_res.ok) begin
                    r_binned <= 1'b1;
                    r_bcol   <= bin_res.col[5:0];
                    r_brow   <= bin_res.row[5:0];
                    r_cell   <= ins_cell;
                    r_base   <= ST_W'(int'(ins_cell) * KEEP_N);
                    r_j      <= '0;
                    r_placed <= 1'b0;
                end
            end
            abtn_pkg::S_FILL_DATA: begin
                r_fill <= fl_rdata;
            end
            abtn_pkg::S_SCAN_EV: begin
                if (scan_write) begin
                    r_carry  <= st_rdata;
                    r_placed <= 1'b1;
                end
                r_j <= r_j + FILL_W'(1);
            end
            abtn_pkg::S_RD_DATA: begin
                if (!r_rd_oob && (r_j < fl_rdata)) begin
                    r_sv    <= 1'b1;
                    r_srefl <= st_rdata[31:16];
                    r_srng  <= st_rdata[15:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_mv;
    assign o_m_axis_tdata  = r_mdata;

endmodule
`default_nettype wire

// ===== hdl/abtn_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module abtn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/abtn_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module abtn_div #(
    parameter int NUM_W = abtn_pkg::DIV_NUM_W,
    parameter int DEN_W = abtn_pkg::DIV_DEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             take;

    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign take   = ~diff[DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== hdl/abtn_bin.sv =====
// Sine and grid index sequencer around the shared divider.
`default_nettype none
module abtn_bin #(
    parameter int GRID_COLS = abtn_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = abtn_pkg::DEF_GRID_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic        [15:0] i_point_range,
    input  wire logic        [15:0] i_hvs,
    output logic                    o_done,
    output abtn_pkg::t_bin_res      o_res
);

    localparam int NW    = abtn_pkg::DIV_NUM_W;
    localparam int DW    = abtn_pkg::DIV_DEN_W;
    localparam int IDX_W = abtn_pkg::IDX_W;
    localparam logic [NW-1:0] CM1_COL = NW'(GRID_COLS - 1);
    localparam logic [NW-1:0] CM1_ROW = NW'(GRID_ROWS - 1);
    localparam logic [NW-1:0] C_COL   = NW'(GRID_COLS);
    localparam logic [NW-1:0] C_ROW   = NW'(GRID_ROWS);

    abtn_pkg::t_bin_state r_st, n_st;

    logic               r_axis;
    logic               r_xneg;
    logic               r_yneg;
    logic [16:0]        r_abs_y;
    logic [15:0]        r_rng;
    logic [15:0]        r_h;
    logic signed [33:0] r_s [2];
    logic signed [33:0] r_sh;
    logic [NW-1:0]      r_t;
    logic [IDX_W-1:0]   r_idx [2];
    logic               r_ok;

    logic          div_start;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [NW-1:0] div_quot;

    logic [16:0]        abs_x;
    logic [16:0]        abs_y;
    logic signed [33:0] s_new;
    logic [NW-1:0]      t_next;
    logic [NW-1:0]      neg_t;
    logic [NW-1:0]      two_h;
    logic               t_neg;
    logic               near_zero;
    logic               q_in_grid;

    assign abs_x = i_pos_x[15] ? (17'd0 - {1'b1, i_pos_x}) : {1'b0, i_pos_x};
    assign abs_y = i_pos_y[15] ? (17'd0 - {1'b1, i_pos_y}) : {1'b0, i_pos_y};

    assign s_new = (r_axis ? r_yneg : r_xneg) ? (34'sd0 - $signed({2'b00, div_quot[31:0]}))
                                               : $signed({2'b00, div_quot[31:0]});
    assign two_h     = NW'({r_h, 1'b0});
    assign t_next    = ((NW'(r_sh) * (r_axis ? CM1_ROW : CM1_COL)) << 1) + two_h;
    assign t_neg     = r_t[NW-1];
    assign neg_t     = NW'(0) - r_t;
    assign near_zero = neg_t < two_h;
    assign q_in_grid = div_quot < (r_axis ? C_ROW : C_COL);

    abtn_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= abtn_pkg::B_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st      = r_st;
        div_start = 1'b0;
        div_num   = {15'd0, abs_x, 16'd0};
        div_den   = {2'b00, i_point_range};
        case (r_st)
            abtn_pkg::B_IDLE: begin
                if (i_start) begin
                    if (i_point_range == 16'd0 || i_hvs == 16'd0) begin
                        n_st = abtn_pkg::B_FIN;
                    end else begin
                        div_start = 1'b1;
                        n_st      = abtn_pkg::B_SINE;
                    end
                end
            end
            abtn_pkg::B_SINE: begin
                div_num = {15'd0, r_abs_y, 16'd0};
                div_den = {2'b00, r_rng};
                if (div_done) begin
                    if (!r_axis) begin
                        div_start = 1'b1;
                    end else begin
                        n_st = abtn_pkg::B_SUM;
                    end
                end
            end
            abtn_pkg::B_SUM: begin
                n_st = abtn_pkg::B_MUL;
            end
            abtn_pkg::B_MUL: begin
                n_st = abtn_pkg::B_IDX;
            end
            abtn_pkg::B_IDX: begin
                div_num = r_t + two_h;
                div_den = {r_h, 2'b00};
                if (!t_neg) begin
                    div_start = 1'b1;
                    n_st      = abtn_pkg::B_QWAIT;
                end else if (near_zero) begin
                    n_st = r_axis ? abtn_pkg::B_FIN : abtn_pkg::B_SUM;
                end else begin
                    n_st = abtn_pkg::B_FIN;
                end
            end
            abtn_pkg::B_QWAIT: begin
                if (div_done) begin
                    if (!q_in_grid || r_axis) begin
                        n_st = abtn_pkg::B_FIN;
                    end else begin
                        n_st = abtn_pkg::B_SUM;
                    end
                end
            end
            abtn_pkg::B_FIN: begin
                n_st = abtn_pkg::B_IDLE;
            end
            default: begin
                n_st = abtn_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            abtn_pkg::B_IDLE: begin
                if (i_start) begin
                    r_ok    <= 1'b0;
                    r_axis  <= 1'b0;
                    r_xneg  <= i_pos_x[15];
                    r_yneg  <= i_pos_y[15];
                    r_abs_y <= abs_y;
                    r_rng   <= i_point_range;
                    r_h     <= i_hvs;
                end
            end
            abtn_pkg::B_SINE: begin
                if (div_done) begin
                    r_s[r_axis] <= s_new;
                    r_axis      <= ~r_axis;
                end
            end
            abtn_pkg::B_SUM: begin
                r_sh <= r_s[r_axis] + $signed({18'd0, r_h});
            end
            abtn_pkg::B_MUL: begin
                r_t <= t_next;
            end
            abtn_pkg::B_IDX: begin
                if (t_neg && near_zero) begin
                    r_idx[r_axis] <= '0;
                    r_ok          <= r_axis;
                    r_axis        <= 1'b1;
                end
            end
            abtn_pkg::B_QWAIT: begin
                if (div_done && q_in_grid) begin
                    r_idx[r_axis] <= div_quot[IDX_W-1:0];
                    r_ok          <= r_axis;
                    r_axis        <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done    = (r_st == abtn_pkg::B_FIN);
    assign o_res.ok  = r_ok;
    assign o_res.col = r_idx[0];
    assign o_res.row = r_idx[1];

endmodule
`default_nettype wire

// ===== hdl/abtn_chk.sv =====
// Port-level checker for the angular binning block, bound to the top level.
`default_nettype none
module abtn_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [47:0] o_m_axis_tdata
);

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while another is in progress");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // An insert result never reports slot contents and a read never reports a cell.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[13]))
        else $error("result marks both binned and slot valid");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[12:1] == 12'd0)
        else $error("unbinned result carries a cell index");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind angular_bin_top_n_reflectivity_core abtn_chk u_abtn_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// ===== verif/angular_bin_top_n_reflectivity_core_tb.sv =====
// Self-checking testbench for the angular binning core with strongest returns kept per cell.
`default_nettype none
module angular_bin_top_n_reflectivity_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS  = abtn_pkg::DEF_GRID_COLS;
    localparam int NROWS  = abtn_pkg::DEF_GRID_ROWS;
    localparam int NKEEP  = abtn_pkg::DEF_KEEP_N;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int N_RANDOM = 1900;
    // Settling time that covers an insert with its divisions and the slot scan.
    localparam int SETTLE_CYCLES = 400;

    // One request as the block sees it.
    typedef struct packed {
        logic        op;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] rng;
        logic [15:0] refl;
        logic [5:0]  rd_col;
        logic [5:0]  rd_row;
        logic [2:0]  rd_slot;
    } t_request;

    // One result of the block, declared from the top bit down so that it lines up
    // with the result tdata.
    typedef struct packed {
        logic [15:0] slot_rng;
        logic [15:0] slot_refl;
        logic        slot_valid;
        logic [5:0]  bin_row;
        logic [5:0]  bin_col;
        logic        binned;
    } t_result;

    // A row of the directed table: the request and, where it is obvious, its result.
    typedef struct {
        t_request req;
        bit       known;
        t_result  res;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // pos_x, pos_y, point_range, reflectivity, read_col, read_row, read_slot, zero pad
    logic [79:0] i_s_axis_tdata;
    // operation
    logic [0:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // binned, bin_col, bin_row, slot_valid, slot_reflectivity, slot_range, zero pad
    logic [47:0] o_m_axis_tdata;

    angular_bin_top_n_reflectivity_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // The predictor's own copy of the grid and of the register.
    logic [15:0] grid_refl [NCELLS*NKEEP];
    logic [15:0] grid_rng  [NCELLS*NKEEP];
    int          grid_fill [NCELLS];
    logic [15:0] view_sine;

    t_result expected_results[$];
    int      error_count;
    bit      stimulus_done;
    bit      idle_sender;
    bit      idle_receiver;
    bit      hold_receiver;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A generous fixed limit: the fill clear, about 2000 requests, stalls and the long
    // hold-off, taken several times over.
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Maps a Q0.16 sine to a grid index; returns -1 when it falls off the grid.
    function automatic longint grid_index(longint s, longint h, longint count);
        longint t;
        longint d;
        longint idx;
        t = 2 * (s + h) * (count - 1) + 2 * h;
        d = 4 * h;
        if (t >= 0) begin
            idx = (t + 2 * h) / d;
        end else if (-t < 2 * h) begin
            idx = 0;
        end else begin
            return -1;
        end
        if (idx >= count) begin
            return -1;
        end
        return idx;
    endfunction

    // Enters a point into a cell, keeping the strongest returns in descending
    // order, earlier arrivals first on equal reflectivity.
    function automatic void rank_into_cell(int cell_no, logic [15:0] refl, logic [15:0] rng);
        int base;
        int pos;
        int k;
        base = cell_no * NKEEP;
        pos = 0;
        while (pos < grid_fill[cell_no] && grid_refl[base+pos] >= refl) begin
            pos++;
        end
        if (pos >= NKEEP) begin
            return;
        end
        k = (grid_fill[cell_no] < NKEEP) ? grid_fill[cell_no] : NKEEP - 1;
        while (k > pos) begin
            grid_refl[base+k] = grid_refl[base+k-1];
            grid_rng[base+k]  = grid_rng[base+k-1];
            k--;
        end
        grid_refl[base+pos] = refl;
        grid_rng[base+pos]  = rng;
        if (grid_fill[cell_no] < NKEEP) begin
            grid_fill[cell_no]++;
        end
    endfunction

    // Works out the result of one request and updates the grid copy.
    function automatic t_result bin_or_read(t_request req);
        t_result res;
        longint x;
        longint y;
        longint r;
        longint h;
        longint col;
        longint row;
        int cell_no;
        res = '0;
        if (req.op == abtn_pkg::OP_INSERT) begin
            x = longint'($signed(req.pos_x));
            y = longint'($signed(req.pos_y));
            r = longint'(req.rng);
            h = longint'(view_sine);
            if (r == 0 || h == 0) begin
                return res;
            end
            col = grid_index((x * 65536) / r, h, NCOLS);
            row = grid_index((y * 65536) / r, h, NROWS);
            if (col < 0 || row < 0) begin
                return res;
            end
            rank_into_cell(int'(col) * NROWS + int'(row), req.refl, req.rng);
            res.binned  = 1'b1;
            res.bin_col = col[5:0];
            res.bin_row = row[5:0];
        end else begin
            cell_no = int'(req.rd_col) * NROWS + int'(req.rd_row);
            if (int'(req.rd_slot) < grid_fill[cell_no]) begin
                res.slot_valid = 1'b1;
                res.slot_refl  = grid_refl[cell_no*NKEEP + req.rd_slot];
                res.slot_rng   = grid_rng[cell_no*NKEEP + req.rd_slot];
            end
        end
        return res;
    endfunction

    // Sends one request, waiting for the block to take it. The random gap comes
    // first so that tvalid is never dropped and raised within one step.
    task automatic send_request(t_request req);
        while (idle_sender && ($urandom_range(99) < 9)) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= req.op;
        i_s_axis_tdata  <= {1'b0, req.rd_slot, req.rd_row, req.rd_col,
                            req.refl, req.rng, req.pos_y, req.pos_x};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_results.insert(expected_results.size(), bin_or_read(req));
    endtask

    // Waits until every result is in, then lets the block settle before a write.
    task automatic drain_and_settle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_view_sine(logic [15:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        view_sine = value;
    endtask

    function automatic t_request insert_request(logic [15:0] x, logic [15:0] y,
                                                logic [15:0] rng, logic [15:0] refl);
        t_request req;
        req = '0;
        req.op    = abtn_pkg::OP_INSERT;
        req.pos_x = x;
        req.pos_y = y;
        req.rng   = rng;
        req.refl  = refl;
        return req;
    endfunction

    function automatic t_request read_request(int col, int row, int slot);
        t_request req;
        req = '0;
        req.op      = abtn_pkg::OP_READ;
        req.rd_col  = col[5:0];
        req.rd_row  = row[5:0];
        req.rd_slot = slot[2:0];
        return req;
    endfunction

    // A random request. Most inserts are aimed near the centre of the view, with
    // coordinates a fraction of the range, so the ranking logic is exercised; the rest
    // are pure noise.
    function automatic t_request random_request();
        t_request req;
        int unsigned pick;
        req = '0;
        req.pos_x = 16'($urandom);
        req.pos_y = 16'($urandom);
        req.rng   = 16'($urandom);
        req.refl  = 16'($urandom);
        req.rd_col = 6'($urandom);
        req.rd_row = 6'($urandom);
        req.rd_slot = 3'($urandom);
        pick = $urandom_range(99);
        if (pick < 35) begin
            req.op = abtn_pkg::OP_READ;
            if ($urandom_range(1)) begin
                req.rd_col = 6'($urandom_range(29, 34));
                req.rd_row = 6'($urandom_range(29, 34));
            end
        end else if (pick < 85) begin
            // Well-formed point inside the view, reflectivity often repeated.
            req.op    = abtn_pkg::OP_INSERT;
            req.rng   = 16'($urandom_range(256, 65535));
            req.pos_x = 16'(int'($urandom_range(0, 400)) - 200) * 16'(req.rng >> 10);
            req.pos_y = 16'(int'($urandom_range(0, 400)) - 200) * 16'(req.rng >> 10);
            if ($urandom_range(3) == 0) begin
                req.refl = 16'($urandom_range(0, 3) * 16'h5555);
            end
        end else begin
            req.op = abtn_pkg::OP_INSERT;
            if ($urandom_range(9) == 0) begin
                req.rng = '0;
            end
        end
        return req;
    endfunction

    // Result side: random stalls, one long hold-off, and the comparison.
    initial begin
        t_result got;
        t_result want;
        i_m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(o_m_axis_tdata[45:0]);
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting: %h", got);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.binned !== want.binned) begin
                        $error("binned: expected %0d, actual %0d", want.binned, got.binned);
                        error_count++;
                    end
                    if (got.bin_col !== want.bin_col) begin
                        $error("bin_col: expected %0d, actual %0d", want.bin_col,
                               got.bin_col);
                        error_count++;
                    end
                    if (got.bin_row !== want.bin_row) begin
                        $error("bin_row: expected %0d, actual %0d", want.bin_row,
                               got.bin_row);
                        error_count++;
                    end
                    if (got.slot_valid !== want.slot_valid) begin
                        $error("slot_valid: expected %0d, actual %0d", want.slot_valid,
                               got.slot_valid);
                        error_count++;
                    end
                    if (got.slot_refl !== want.slot_refl) begin
                        $error("slot_reflectivity: expected %0d, actual %0d",
                               want.slot_refl, got.slot_refl);
                        error_count++;
                    end
                    if (got.slot_rng !== want.slot_rng) begin
                        $error("slot_range: expected %0d, actual %0d", want.slot_rng,
                               got.slot_rng);
                        error_count++;
                    end
                end
            end
            if (hold_receiver) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !(idle_receiver && ($urandom_range(99) < 9));
            end
        end
    end

    // Long hold-off on the result side, counted in cycles, once the random part
    // is under way: the sender keeps offering and the block must stall its input.
    initial begin
        hold_receiver = 1'b0;
        wait (stimulus_done == 1'b0 && idle_sender);
        repeat (3000) @(posedge i_clk);
        hold_receiver = 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_receiver = 1'b0;
    end

    initial begin
        t_directed_row rows[$];
        t_directed_row row;
        t_result       obvious;
        t_request      req;
        logic [15:0]   sine_settings[4];

        error_count   = 0;
        stimulus_done = 1'b0;
        idle_sender   = 1'b0;
        idle_receiver = 1'b0;
        view_sine     = abtn_pkg::HVS_RESET;
        for (int c = 0; c < NCELLS; c++) begin
            grid_fill[c] = 0;
        end
        i_rst_n         <= 1'b0;
        i_cfg_wen       <= 1'b0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= abtn_pkg::OP_INSERT;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, run with the reset value of the register. Results that
        // can be read off directly are typed in; the rest go to the predictor.
        obvious = '0;
        // Reads of an empty grid give zeros, including the far corner.
        rows.insert(rows.size(), '{read_request(0, 0, 0), 1'b1, obvious});
        rows.insert(rows.size(), '{read_request(63, 63, 7), 1'b1, obvious});
        // Zero range is dropped.
        rows.insert(rows.size(), '{insert_request(16'h0100, 16'h0100, 16'h0000, 16'hFFFF),
                                   1'b1, obvious});
        // A point straight ahead lands in the centre cell.
        rows.insert(rows.size(), '{insert_request(16'h0000, 16'h0000, 16'h0100, 16'h1234),
                                   1'b0, obvious});
        // Far off axis: outside the grid.
        rows.insert(rows.size(), '{insert_request(16'h7FFF, 16'h0000, 16'h0001, 16'h0001),
                                   1'b1, obvious});
        rows.insert(rows.size(), '{insert_request(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF),
                                   1'b0, obvious});
        rows.insert(rows.size(), '{insert_request(16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000),
                                   1'b0, obvious});
        // Ten more points into the centre cell: ties, the weakest pushed out, and a
        // point that ranks below a full cell.
        for (int i = 0; i < 10; i++) begin
            rows.insert(rows.size(), '{insert_request(16'h0000, 16'h0000, 16'(16'h0200 + i),
                                                      16'((i % 3) * 16'h4000)),
                                       1'b0, obvious});
        end
        for (int s = 0; s < NKEEP; s++) begin
            rows.insert(rows.size(), '{read_request(32, 32, s), 1'b0, obvious});
        end

        foreach (rows[i]) begin
            row = rows[i];
            send_request(row.req);
            if (row.known && expected_results[$] !== row.res) begin
                $error("table row %0d: expected %h, predicted %h", i, row.res,
                       expected_results[$]);
                error_count++;
            end
        end
        drain_and_settle();

        // Random part across several view settings, the extremes among them.
        sine_settings[0] = 16'd1;
        sine_settings[1] = 16'hFFFF;
        sine_settings[2] = 16'($urandom_range(1000, 60000));
        sine_settings[3] = abtn_pkg::HVS_RESET;
        idle_sender   = 1'b1;
        idle_receiver = 1'b1;
        for (int p = 0; p < 4; p++) begin
            write_view_sine(sine_settings[p]);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                // A quiet stretch without random gaps in the third phase.
                idle_sender   = (p != 2);
                idle_receiver = (p != 2);
                req = random_request();
                send_request(req);
            end
            drain_and_settle();
        end
        // A zero view sine drops every insert.
        write_view_sine(16'd0);
        for (int n = 0; n < 8; n++) begin
            send_request(random_request());
        end
        i_s_axis_tvalid <= 1'b0;
        stimulus_done = 1'b1;

        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
